// File: hw/rtl/mvt_pkg.sv
package mvt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MAT_N = 16;
  localparam int unsigned MAT_DIM = 4;
  // truncated product keeps bits 63:16 of the exact product
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W - FRAC_W;
  // four 48-bit terms need two guard bits
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_IDENTITY  = 2'd0;
  localparam logic [1:0] OP_SCALE     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_TRANSFORM = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef logic signed [DATA_W-1:0] matrix_t [MAT_N];

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    logic wr_mat;
    logic emits;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t s;
    logic [SUM_W-DATA_W:0] hi;
    hi = v[SUM_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      s.value = v[DATA_W-1:0];
      s.ovf = 1'b0;
    end else begin
      s.value = v[SUM_W-1] ? S32_MIN : S32_MAX;
      s.ovf = 1'b1;
    end
    return s;
  endfunction

  function automatic matrix_t identity();
    matrix_t m;
    for (int c = 0; c < MAT_DIM; c++) begin
      for (int r = 0; r < MAT_DIM; r++) begin
        m[c * MAT_DIM + r] = (c == r) ? Q_ONE : '0;
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/mvt_in_if.sv
interface mvt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic signed [mvt_pkg::DATA_W-1:0]   in_x;
  logic signed [mvt_pkg::DATA_W-1:0]   in_y;
  logic signed [mvt_pkg::DATA_W-1:0]   in_z;
  logic signed [mvt_pkg::DATA_W-1:0]   in_w;

  modport source (output valid, operation, in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, operation, in_x, in_y, in_z, in_w, output ready);
endinterface

// File: hw/rtl/mvt_out_if.sv
interface mvt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvt_pkg::DATA_W-1:0]   out_x;
  logic signed [mvt_pkg::DATA_W-1:0]   out_y;
  logic signed [mvt_pkg::DATA_W-1:0]   out_z;
  logic signed [mvt_pkg::DATA_W-1:0]   out_w;
  logic                                saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

// File: hw/rtl/mvt_front.sv
module mvt_front #(
  parameter int unsigned QUEUE_DEPTH = mvt_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  mvt_in_if.sink         in_chan,
  output mvt_pkg::head_t head,
  input  logic           pop
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  mvt_pkg::cmd_t    q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             do_pop;
  mvt_pkg::cmd_t    in_cmd;

  assign in_chan.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push = in_chan.valid && in_chan.ready;
  assign do_pop = pop && (count_r != '0);

  assign in_cmd.op = in_chan.operation;
  assign in_cmd.x  = in_chan.in_x;
  assign in_cmd.y  = in_chan.in_y;
  assign in_cmd.z  = in_chan.in_z;
  assign in_cmd.w  = in_chan.in_w;

  // classify the head: everything but a vector transform rewrites the matrix
  always_comb begin
    head.valid  = (count_r != '0);
    head.cmd    = q_mem[rd_ptr_r];
    head.emits  = (q_mem[rd_ptr_r].op == mvt_pkg::OP_TRANSFORM);
    head.wr_mat = (q_mem[rd_ptr_r].op != mvt_pkg::OP_TRANSFORM);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// File: hw/rtl/mvt_back.sv
module mvt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mvt_pkg::head_t head,
  output logic           pop,
  mvt_out_if.source      out_chan
);

  localparam int unsigned DW  = mvt_pkg::DATA_W;
  localparam int unsigned PW  = mvt_pkg::PROD_W;
  localparam int unsigned SW  = mvt_pkg::SUM_W;
  localparam int unsigned N   = mvt_pkg::MAT_N;
  localparam int unsigned DIM = mvt_pkg::MAT_DIM;

  mvt_pkg::matrix_t     mat_r, mat_nxt;
  logic                 ovf_r;

  // stage 1: operands in front of the multipliers
  logic                 s1_valid_r;
  logic                 s1_wr_r;
  logic                 s1_emits_r;
  logic [1:0]           s1_op_r;
  logic signed [DW-1:0] s1_v_r [DIM];

  // stage 2: registered truncated products
  logic                 s2_valid_r;
  logic                 s2_emits_r;
  logic [1:0]           s2_op_r;
  logic signed [PW-1:0] s2_prod_r [N];

  logic signed [PW-1:0] prod [N];
  logic signed [DW-1:0] res [DIM];
  logic                 ovf_any;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_x_r, out_y_r, out_z_r, out_w_r;
  logic                 out_sat_r;

  logic                 adv;

  assign adv = !out_valid_r || out_chan.ready;
  // hold issue while a matrix update sits in stage 1 so the next item sees the new matrix
  assign pop = head.valid && adv && !(s1_valid_r && s1_wr_r);

  always_comb begin
    logic signed [2*DW-1:0] full;
    logic signed [DW-1:0]   vsel;
    full = '0;
    vsel = '0;
    for (int k = 0; k < DIM; k++) begin
      for (int r = 0; r < DIM; r++) begin
        vsel = (s1_op_r == mvt_pkg::OP_SCALE) ? s1_v_r[0] : s1_v_r[k];
        full = (2*DW)'(mat_r[k * DIM + r]) * (2*DW)'(vsel);
        prod[k * DIM + r] = full[2*DW-1:mvt_pkg::FRAC_W];
      end
    end
  end

  always_comb begin
    mvt_pkg::sat_t        s;
    logic signed [SW-1:0] sum;
    s = '0;
    sum = '0;
    mat_nxt = mat_r;
    ovf_any = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      res[r] = '0;
    end
    case (s2_op_r)
      mvt_pkg::OP_IDENTITY: begin
        mat_nxt = mvt_pkg::identity();
      end
      mvt_pkg::OP_SCALE: begin
        for (int i = 0; i < N - DIM; i++) begin
          s = mvt_pkg::sat32(SW'(s2_prod_r[i]));
          mat_nxt[i] = s.value;
          ovf_any = ovf_any | s.ovf;
        end
      end
      mvt_pkg::OP_TRANSLATE: begin
        for (int r = 0; r < DIM; r++) begin
          sum = SW'(s2_prod_r[r]) + SW'(s2_prod_r[DIM + r]) + SW'(s2_prod_r[2*DIM + r])
              + SW'(mat_r[3*DIM + r]);
          s = mvt_pkg::sat32(sum);
          mat_nxt[3*DIM + r] = s.value;
          ovf_any = ovf_any | s.ovf;
        end
      end
      mvt_pkg::OP_TRANSFORM: begin
        for (int r = 0; r < DIM; r++) begin
          sum = SW'(s2_prod_r[r]) + SW'(s2_prod_r[DIM + r]) + SW'(s2_prod_r[2*DIM + r])
              + SW'(s2_prod_r[3*DIM + r]);
          s = mvt_pkg::sat32(sum);
          res[r] = s.value;
          ovf_any = ovf_any | s.ovf;
        end
      end
      default: begin
        mat_nxt = mat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      mat_r       <= mvt_pkg::identity();
    end else if (adv) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_emits_r;
      if (s2_valid_r) begin
        ovf_r <= ovf_r | ovf_any;
        if (!s2_emits_r) begin
          mat_r <= mat_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        s1_op_r    <= head.cmd.op;
        s1_wr_r    <= head.wr_mat;
        s1_emits_r <= head.emits;
        s1_v_r[0]  <= head.cmd.x;
        s1_v_r[1]  <= head.cmd.y;
        s1_v_r[2]  <= head.cmd.z;
        s1_v_r[3]  <= head.cmd.w;
      end
      s2_op_r    <= s1_op_r;
      s2_emits_r <= s1_emits_r;
      s2_prod_r  <= prod;
      if (s2_valid_r && s2_emits_r) begin
        out_x_r   <= res[0];
        out_y_r   <= res[1];
        out_z_r   <= res[2];
        out_w_r   <= res[3];
        out_sat_r <= ovf_r | ovf_any;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_x     = out_x_r;
  assign out_chan.out_y     = out_y_r;
  assign out_chan.out_z     = out_z_r;
  assign out_chan.out_w     = out_w_r;
  assign out_chan.saturated = out_sat_r;

endmodule

// File: hw/rtl/matrix_vector_transform_4x4.sv
// 4x4 homogeneous transform in signed Q16.16. Vector transforms stream at one
// per cycle while out_chan.ready stays high, with the result registered through
// the queue, the multiplier stage and the sum and saturate stage on its way to
// out_chan. Identity, scale and translate requests rewrite the matrix at the
// end of the two-stage multiply-add pipeline, so the request after one of them
// is held at issue until the update has left the operand stage.
// Sixteen 32x32 multipliers run in parallel; a small input queue keeps
// in_chan.ready up while the output side stalls, until the queue fills.
// The matrix resets to identity and the sticky saturated flag to zero.
module matrix_vector_transform_4x4 #(
  parameter int unsigned QUEUE_DEPTH = mvt_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  mvt_in_if.sink    in_chan,
  mvt_out_if.source out_chan
);

  mvt_pkg::head_t head;
  logic           pop;

  mvt_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .head    (head),
    .pop     (pop)
  );

  mvt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// File: hw/rtl/mvt_checker.sv
module mvt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        in_operation,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mvt_pkg::DATA_W-1:0] out_x,
  input logic signed [mvt_pkg::DATA_W-1:0] out_y,
  input logic signed [mvt_pkg::DATA_W-1:0] out_z,
  input logic signed [mvt_pkg::DATA_W-1:0] out_w,
  input logic                              saturated
);

  // transform requests accepted but not yet delivered
  logic [3:0] pend_r;
  logic       in_tx;
  logic       out_tx;

  assign in_tx  = in_valid && in_ready && (in_operation == mvt_pkg::OP_TRANSFORM);
  assign out_tx = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {3'b000, in_tx} - {3'b000, out_tx};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
      && $stable(out_w) && $stable(saturated))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a pending transform request");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tx && saturated |=> !out_valid || saturated)
    else $error("saturated flag cleared after being reported");

endmodule

bind matrix_vector_transform_4x4 mvt_checker u_mvt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_operation (in_chan.operation),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_x        (out_chan.out_x),
  .out_y        (out_chan.out_y),
  .out_z        (out_chan.out_z),
  .out_w        (out_chan.out_w),
  .saturated    (out_chan.saturated)
);

// File: bench/tb_matrix_vector_transform_4x4.sv
module tb_matrix_vector_transform_4x4;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS = 40;
  localparam logic signed [mvt_pkg::DATA_W-1:0] Q_NEG_ONE = 32'shffff_0000;

  typedef struct packed {
    logic [mvt_pkg::MAT_DIM-1:0][mvt_pkg::DATA_W-1:0] comp;
    logic                                             sat;
  } vec_result_t;

  logic clk;
  logic rst_n;

  mvt_in_if  in_bus ();
  mvt_out_if out_bus ();

  matrix_vector_transform_4x4 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  mvt_pkg::cmd_t cmd_queue [$];
  vec_result_t   expected_vectors [$];
  mvt_pkg::cmd_t cur_cmd;

  // transform state as the block should hold it
  logic signed [mvt_pkg::DATA_W-1:0] mat_model [mvt_pkg::MAT_N];
  bit                                ovf_sticky;

  int send_idle_pct = 31;
  int recv_idle_pct = 50;
  int err_count = 0;
  int cycle_count = 0;
  int n_updates = 0;
  int n_vectors = 0;
  int n_checked = 0;
  int n_sat_results = 0;

  string lane_name [mvt_pkg::MAT_DIM] = '{"out_x", "out_y", "out_z", "out_w"};

  // exact product, floor shift back to Q16.16
  function automatic longint qprod(input logic signed [mvt_pkg::DATA_W-1:0] a,
                                   input logic signed [mvt_pkg::DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> mvt_pkg::FRAC_W;
  endfunction

  function automatic logic signed [mvt_pkg::DATA_W-1:0] clamp32(input longint s);
    if (s > longint'(mvt_pkg::S32_MAX)) begin
      ovf_sticky = 1'b1;
      return mvt_pkg::S32_MAX;
    end
    if (s < longint'(mvt_pkg::S32_MIN)) begin
      ovf_sticky = 1'b1;
      return mvt_pkg::S32_MIN;
    end
    return s[mvt_pkg::DATA_W-1:0];
  endfunction

  task automatic load_identity_model();
    for (int i = 0; i < mvt_pkg::MAT_N; i++) begin
      mat_model[i] = ((i % 5) == 0) ? mvt_pkg::Q_ONE : '0;
    end
  endtask

  task automatic apply_command(input mvt_pkg::cmd_t c);
    logic signed [mvt_pkg::DATA_W-1:0] v [mvt_pkg::MAT_DIM];
    longint                            s;
    vec_result_t                       res;
    v[0] = c.x;
    v[1] = c.y;
    v[2] = c.z;
    v[3] = c.w;
    case (c.op)
      mvt_pkg::OP_IDENTITY: begin
        load_identity_model();
        n_updates++;
      end
      mvt_pkg::OP_SCALE: begin
        for (int k = 0; k < 12; k++) begin
          mat_model[k] = clamp32(qprod(mat_model[k], c.x));
        end
        n_updates++;
      end
      mvt_pkg::OP_TRANSLATE: begin
        // column 3 depends only on columns 0..2 and itself, so in place is safe
        for (int r = 0; r < mvt_pkg::MAT_DIM; r++) begin
          s = qprod(mat_model[r], c.x) + qprod(mat_model[4 + r], c.y)
            + qprod(mat_model[8 + r], c.z) + longint'(mat_model[12 + r]);
          mat_model[12 + r] = clamp32(s);
        end
        n_updates++;
      end
      default: begin
        for (int r = 0; r < mvt_pkg::MAT_DIM; r++) begin
          s = 0;
          for (int k = 0; k < mvt_pkg::MAT_DIM; k++) begin
            s += qprod(mat_model[k * mvt_pkg::MAT_DIM + r], v[k]);
          end
          res.comp[r] = clamp32(s);
        end
        res.sat = ovf_sticky;
        expected_vectors.push_back(res);
        n_vectors++;
      end
    endcase
  endtask

  function automatic logic signed [mvt_pkg::DATA_W-1:0] rand_q();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return int'($urandom_range(32'h8_0000)) - 32'sh4_0000;
    end else if (pick < 65) begin
      return int'($urandom_range(32'h2_0000)) - 32'sh1_0000;
    end else if (pick < 90) begin
      return $urandom;
    end
    case ($urandom_range(6))
      0: return mvt_pkg::S32_MAX;
      1: return mvt_pkg::S32_MIN;
      2: return '0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return mvt_pkg::Q_ONE;
      default: return Q_NEG_ONE;
    endcase
  endfunction

  // scale factors near unity keep the matrix from pinning at the rails
  function automatic logic signed [mvt_pkg::DATA_W-1:0] rand_scale();
    logic signed [mvt_pkg::DATA_W-1:0] f;
    if ($urandom_range(99) < 60) begin
      f = $urandom_range(32'h2_0000, 32'h0_4000);
      return $urandom_range(1) ? -f : f;
    end
    return rand_q();
  endfunction

  task automatic push_cmd(input logic [1:0] op,
                          input logic signed [mvt_pkg::DATA_W-1:0] x,
                          input logic signed [mvt_pkg::DATA_W-1:0] y,
                          input logic signed [mvt_pkg::DATA_W-1:0] z,
                          input logic signed [mvt_pkg::DATA_W-1:0] w);
    mvt_pkg::cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.z = z;
    c.w = w;
    cmd_queue.push_back(c);
  endtask

  task automatic push_directed();
    push_cmd(mvt_pkg::OP_TRANSFORM, 32'sh0001_8000, 32'shfffd_c000, 32'sh0003_0000,
             mvt_pkg::Q_ONE);
    push_cmd(mvt_pkg::OP_SCALE, 32'sh0002_0000, $urandom, $urandom, $urandom);
    push_cmd(mvt_pkg::OP_TRANSLATE, mvt_pkg::Q_ONE, Q_NEG_ONE, 32'sh0000_8000, $urandom);
    push_cmd(mvt_pkg::OP_TRANSFORM, mvt_pkg::Q_ONE, mvt_pkg::Q_ONE, mvt_pkg::Q_ONE,
             mvt_pkg::Q_ONE);
    push_cmd(mvt_pkg::OP_TRANSFORM, '0, '0, '0, mvt_pkg::Q_ONE);
    push_cmd(mvt_pkg::OP_IDENTITY, $urandom, $urandom, $urandom, $urandom);
    push_cmd(mvt_pkg::OP_TRANSFORM, mvt_pkg::S32_MAX, mvt_pkg::S32_MAX, mvt_pkg::S32_MAX,
             mvt_pkg::S32_MAX);
    push_cmd(mvt_pkg::OP_TRANSFORM, mvt_pkg::S32_MIN, mvt_pkg::S32_MIN, mvt_pkg::S32_MIN,
             mvt_pkg::S32_MIN);
    push_cmd(mvt_pkg::OP_SCALE, '0, '0, '0, '0);
    push_cmd(mvt_pkg::OP_TRANSFORM, 32'sh0005_0000, 32'sh0007_0000, -32'sh0003_0000,
             mvt_pkg::Q_ONE);
    push_cmd(mvt_pkg::OP_IDENTITY, '0, '0, '0, '0);
    push_cmd(mvt_pkg::OP_SCALE, Q_NEG_ONE, '1, '1, '1);
    push_cmd(mvt_pkg::OP_TRANSFORM, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
             32'sh0004_0000);
    push_cmd(mvt_pkg::OP_SCALE, mvt_pkg::S32_MAX, '0, '0, '0);
    // rows now near the rails: sums overflow
    push_cmd(mvt_pkg::OP_TRANSFORM, mvt_pkg::S32_MAX, mvt_pkg::S32_MIN, mvt_pkg::S32_MAX,
             mvt_pkg::Q_ONE);
    push_cmd(mvt_pkg::OP_SCALE, mvt_pkg::S32_MIN, '0, '0, '0);
    push_cmd(mvt_pkg::OP_TRANSLATE, mvt_pkg::S32_MAX, mvt_pkg::S32_MAX, mvt_pkg::S32_MAX,
             '0);
    push_cmd(mvt_pkg::OP_TRANSFORM, mvt_pkg::S32_MIN, mvt_pkg::S32_MIN, mvt_pkg::S32_MIN,
             mvt_pkg::S32_MIN);
    push_cmd(mvt_pkg::OP_IDENTITY, '1, '1, '1, '1);
    push_cmd(mvt_pkg::OP_TRANSLATE, mvt_pkg::S32_MIN, mvt_pkg::S32_MIN, mvt_pkg::S32_MIN,
             mvt_pkg::S32_MAX);
    push_cmd(mvt_pkg::OP_TRANSFORM, mvt_pkg::Q_ONE, mvt_pkg::Q_ONE, mvt_pkg::Q_ONE,
             mvt_pkg::S32_MAX);
    // one lsb negative scale exercises floor truncation
    push_cmd(mvt_pkg::OP_SCALE, -32'sd1, '0, '0, '0);
    push_cmd(mvt_pkg::OP_TRANSFORM, 32'sh0003_0001, -32'sh0002_0001, 32'sd1, -32'sd1);
    push_cmd(mvt_pkg::OP_TRANSFORM, '1, '1, '1, '1);
  endtask

  task automatic push_random(input int n_items);
    int start;
    int reps;
    start = cmd_queue.size();
    while (cmd_queue.size() - start < n_items) begin
      if ($urandom_range(99) < 15) begin
        push_cmd(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        if ($urandom_range(99) < 70) begin
          push_cmd(mvt_pkg::OP_IDENTITY, $urandom, $urandom, $urandom, $urandom);
        end
        reps = $urandom_range(2);
        for (int i = 0; i < reps; i++) begin
          push_cmd(mvt_pkg::OP_SCALE, rand_scale(), $urandom, $urandom, $urandom);
        end
        reps = $urandom_range(2);
        for (int i = 0; i < reps; i++) begin
          push_cmd(mvt_pkg::OP_TRANSLATE, rand_q(), rand_q(), rand_q(), $urandom);
        end
        reps = $urandom_range(6, 1);
        for (int i = 0; i < reps; i++) begin
          push_cmd(mvt_pkg::OP_TRANSFORM, rand_q(), rand_q(), rand_q(),
                   ($urandom_range(1) ? mvt_pkg::Q_ONE : rand_q()));
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = '0;
    in_bus.in_x = '0;
    in_bus.in_y = '0;
    in_bus.in_z = '0;
    in_bus.in_w = '0;
    out_bus.ready = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               expected_vectors.size());
      $display("tb_matrix_vector_transform_4x4 failed");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      load_identity_model();
      ovf_sticky = 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        apply_command(cur_cmd);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.operation <= cur_cmd.op;
          in_bus.in_x <= cur_cmd.x;
          in_bus.in_y <= cur_cmd.y;
          in_bus.in_z <= cur_cmd.z;
          in_bus.in_w <= cur_cmd.w;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    vec_result_t want;
    logic [mvt_pkg::MAT_DIM-1:0][mvt_pkg::DATA_W-1:0] got;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.out_w, out_bus.out_z, out_bus.out_y, out_bus.out_x};
        if (expected_vectors.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none, got %h %h %h %h sat %b",
                     $time, got[0], got[1], got[2], got[3], out_bus.saturated);
          end
        end else begin
          want = expected_vectors.pop_front();
          n_checked++;
          if (want.sat) begin
            n_sat_results++;
          end
          for (int r = 0; r < mvt_pkg::MAT_DIM; r++) begin
            if (got[r] !== want.comp[r]) begin
              err_count++;
              if (err_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time,
                         lane_name[r], want.comp[r], got[r]);
              end
            end
          end
          if (out_bus.saturated !== want.sat) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: saturated mismatch, expected %b, actual %b", $time,
                       want.sat, out_bus.saturated);
            end
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    push_directed();
    push_random(530);
    while (cmd_queue.size() != 0) @(negedge clk);

    send_idle_pct = 50;
    recv_idle_pct = 31;
    push_random(530);
    while (cmd_queue.size() != 0) @(negedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(540);
    while (cmd_queue.size() != 0 || in_bus.valid) @(negedge clk);
    while (expected_vectors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d matrix updates and %0d vector transforms", n_updates,
             n_vectors);
    $display("%0d results checked, %0d of them with the overflow flag set, %0d errors",
             n_checked, n_sat_results, err_count);
    if (err_count == 0) begin
      $display("tb_matrix_vector_transform_4x4 passed");
    end else begin
      $display("tb_matrix_vector_transform_4x4 failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_in_if.sv
hw/rtl/mvt_out_if.sv
hw/rtl/mvt_front.sv
hw/rtl/mvt_back.sv
hw/rtl/matrix_vector_transform_4x4.sv
hw/rtl/mvt_checker.sv
bench/tb_matrix_vector_transform_4x4.sv
